// ===== sv/ramsete_trajectory_tracker_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RAMSETE tracker checker
// ----------------------------------------------------------------------------
`ifndef RAMSETE_TRAJECTORY_TRACKER_TOP_ASSERT_SVH
`define RAMSETE_TRAJECTORY_TRACKER_TOP_ASSERT_SVH

// Clocked check, masked while reset is high.
`define RTT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also runs through reset.
`define RTT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared widths, constants and types of the RAMSETE tracker.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int XW        = 32;  // Q16.16 fields
  localparam int AW        = 16;  // binary angles
  localparam int CW        = 24;  // config registers
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = 63;  // clamped product, +-2^61

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZETA = 1'b0,
    CFG_BETA = 1'b1
  } cfg_idx_t;

  localparam logic [CW-1:0] ZETA_RST = 24'd45875;
  localparam logic [CW-1:0] BETA_RST = 24'd131072;

  // quarter-wave sine polynomial
  localparam logic [16:0] TRIG_C1 = 17'd102944;
  localparam logic [15:0] TRIG_C3 = 16'd42048;
  localparam logic [12:0] TRIG_C5 = 13'd4640;

  localparam logic [63:0] PROD_LIM = 64'h2000_0000_0000_0000;

  typedef struct packed {
    logic [14:0] r;    // 0..16384 within the quarter
    logic        neg;  // lower half-circle
  } trig_arg_t;

endpackage

// ===== sv/rtt_pose_if.sv =====
// ----------------------------------------------------------------------------
// rtt_pose_if
// Pose and goal item channel.
// ----------------------------------------------------------------------------
interface rtt_pose_if;
  logic                              valid;
  logic                              ready;
  logic signed [rtt_pkg::XW-1:0]     robot_x;
  logic signed [rtt_pkg::XW-1:0]     robot_y;
  logic signed [rtt_pkg::AW-1:0]     robot_heading;
  logic signed [rtt_pkg::XW-1:0]     target_x;
  logic signed [rtt_pkg::XW-1:0]     target_y;
  logic signed [rtt_pkg::AW-1:0]     target_heading;
  logic signed [rtt_pkg::XW-1:0]     target_speed;
  logic signed [rtt_pkg::XW-1:0]     target_turn_rate;

  modport source (
    output valid, robot_x, robot_y, robot_heading, target_x, target_y,
           target_heading, target_speed, target_turn_rate,
    input  ready
  );
  modport sink (
    input  valid, robot_x, robot_y, robot_heading, target_x, target_y,
           target_heading, target_speed, target_turn_rate,
    output ready
  );
endinterface

// ===== sv/rtt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// rtt_cmd_if
// Velocity command item channel.
// ----------------------------------------------------------------------------
interface rtt_cmd_if;
  logic                          valid;
  logic                          ready;
  logic signed [rtt_pkg::XW-1:0] command_speed;
  logic signed [rtt_pkg::XW-1:0] command_turn_rate;
  logic                          saturated;

  modport source (
    output valid, command_speed, command_turn_rate, saturated,
    input  ready
  );
  modport sink (
    input  valid, command_speed, command_turn_rate, saturated,
    output ready
  );
endinterface

// ===== sv/rtt_qsin.sv =====
// ----------------------------------------------------------------------------
// rtt_qsin
// Four-stage quarter-wave sine of a reduced binary angle, signed Q16 out.
// ----------------------------------------------------------------------------
module rtt_qsin (
  input  logic                       clk,
  input  logic                       en,
  input  rtt_pkg::trig_arg_t         arg,
  output logic signed [17:0]         sin_q16
);

  logic [14:0] r1, r2, r3;
  logic        n1, n2, n3;
  logic [14:0] z1, z2;
  logic [12:0] t1;
  logic [15:0] t2;

  logic [29:0] rr;
  logic [27:0] c5z;
  logic [15:0] d3;
  logic [30:0] p3;
  logic [16:0] d4;
  logic [31:0] p4;
  logic [16:0] s4;

  always_comb begin
    rr  = arg.r * arg.r;
    c5z = rtt_pkg::TRIG_C5 * z1;
    d3  = rtt_pkg::TRIG_C3 - 16'(t1);
    p3  = d3 * z2;
    d4  = rtt_pkg::TRIG_C1 - 17'(t2);
    p4  = d4 * r3;
    s4  = p4[30:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1      <= rr[28:14];
      r1      <= arg.r;
      n1      <= arg.neg;
      t1      <= c5z[26:14];
      z2      <= z1;
      r2      <= r1;
      n2      <= n1;
      t2      <= p3[29:14];
      r3      <= r2;
      n3      <= n2;
      sin_q16 <= n3 ? -$signed({1'b0, s4}) : $signed({1'b0, s4});
    end
  end

endmodule

// ===== sv/rtt_mul.sv =====
// ----------------------------------------------------------------------------
// rtt_mul
// Four-stage signed multiply, truncating shift toward zero, clamp to +-2^61.
// Operands wider than 32 bits are split into a low 32-bit limb and an upper limb.
// ----------------------------------------------------------------------------
module rtt_mul #(
  parameter int WA    = 46,
  parameter int WB    = 36,
  parameter int SHIFT = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [WA-1:0]               a,
  input  logic signed [WB-1:0]               b,
  output logic signed [rtt_pkg::PROD_W-1:0]  p
);

  localparam int AH = WA - 32;
  localparam int BH = WB - 32;
  localparam int PW = WA + WB;
  localparam logic [PW-1:0] LIM = PW'(rtt_pkg::PROD_LIM);

  logic [WA-1:0]    ua;
  logic [WB-1:0]    ub;
  logic             n1, n2, n3;
  logic [63:0]      pp0;
  logic [BH+31:0]   pp1;
  logic [AH+31:0]   pp2;
  logic [AH+BH-1:0] pp3;
  logic [PW-1:0]    full;
  logic [PW-1:0]    q;
  logic [rtt_pkg::PROD_W-2:0] mag;

  always_comb begin
    q   = full >> SHIFT;
    mag = (q > LIM) ? LIM[rtt_pkg::PROD_W-2:0] : q[rtt_pkg::PROD_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1   <= a[WA-1] ^ b[WB-1];
      ua   <= a[WA-1] ? (~a + 1'b1) : a;
      ub   <= b[WB-1] ? (~b + 1'b1) : b;
      n2   <= n1;
      pp0  <= ua[31:0] * ub[31:0];
      pp1  <= ua[31:0] * ub[WB-1:32];
      pp2  <= ua[WA-1:32] * ub[31:0];
      pp3  <= ua[WA-1:32] * ub[WB-1:32];
      n3   <= n2;
      full <= PW'(pp0) + (PW'(pp1) << 32) + (PW'(pp2) << 32) + (PW'(pp3) << 64);
      p    <= n3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

// ===== sv/ramsete_trajectory_tracker_top.sv =====
// ----------------------------------------------------------------------------
// ramsete_trajectory_tracker_top
// Fixed-point RAMSETE unicycle tracking controller, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  pose_in   in   valid/ready    robot pose, goal pose, goal v and w
//  cmd_out   out  valid/ready    command v, command w, saturated flag
//  cfg       in   cfg_we         cfg_index, cfg_data (zeta, beta)
//
//  One item per cycle unless cmd_out stalls; the 32-stage square-root
//  pipeline of the gain path (one root bit per stage) dominates the depth.
//  Reset clears the valid bits and loads zeta and beta defaults.
//  A stall on cmd_out freezes every stage together; a bubble lets
//  ready stay high so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ramsete_trajectory_tracker_top (
  input  logic                              clk,
  input  logic                              rst,
  rtt_pose_if.sink                          pose_in,
  rtt_cmd_if.source                         cmd_out,
  input  logic                              cfg_we,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtt_pkg::CW-1:0]            cfg_data
);

  localparam int KW  = 45;  // gain k, unsigned Q29.16
  localparam int EW  = 36;  // e_x, e_y
  localparam int RW  = 19;  // heading error in radians
  localparam int BVW = 41;  // beta*v_d and beta*v_d*sinc

  localparam logic signed [63:0] PI_Q16 = 64'sd205887;

  // truncating arithmetic shift (toward zero)
  function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
                                                    input logic [5:0] sh);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (v + bias) >>> sh;
  endfunction

  // quadrant reduction of a binary angle
  function automatic rtt_pkg::trig_arg_t reduce(input logic [15:0] ang);
    rtt_pkg::trig_arg_t t;
    t.neg = ang[15];
    t.r   = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic [rtt_pkg::CW-1:0] zeta, beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      zeta <= rtt_pkg::ZETA_RST;
      beta <= rtt_pkg::BETA_RST;
    end else if (cfg_we) begin
      unique case (rtt_pkg::cfg_idx_t'(cfg_index))
        rtt_pkg::CFG_ZETA: zeta <= cfg_data;
        rtt_pkg::CFG_BETA: beta <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: one global advance, valid bits per stage
  // --------------------------------------------------------------------------
  logic [44:1] vld;
  logic        en;

  assign en            = !vld[44] || cmd_out.ready;
  assign pose_in.ready = en;
  assign cmd_out.valid = vld[44];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[43:1], pose_in.valid};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: differences and trig argument reduction
  // --------------------------------------------------------------------------
  logic signed [32:0] dx1, dy1;
  logic signed [15:0] eb1;
  logic signed [31:0] vd1, wd1;
  rtt_pkg::trig_arg_t a_sr1, a_cr1, a_se1, a_ce1;
  logic [15:0]        ediff;

  assign ediff = pose_in.target_heading - pose_in.robot_heading;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= 33'(pose_in.target_x) - 33'(pose_in.robot_x);
      dy1   <= 33'(pose_in.target_y) - 33'(pose_in.robot_y);
      eb1   <= $signed(ediff);
      vd1   <= pose_in.target_speed;
      wd1   <= pose_in.target_turn_rate;
      a_sr1 <= reduce(pose_in.robot_heading);
      a_cr1 <= reduce(16'(pose_in.robot_heading + 16'h4000));
      a_se1 <= reduce(ediff);
      a_ce1 <= reduce(16'(ediff + 16'h4000));
    end
  end

  // stages 2..5: sin/cos of robot heading and of heading error
  logic signed [17:0] sr5, cr5, se5, ce5;

  rtt_qsin u_sin_r (.clk(clk), .en(en), .arg(a_sr1), .sin_q16(sr5));
  rtt_qsin u_cos_r (.clk(clk), .en(en), .arg(a_cr1), .sin_q16(cr5));
  rtt_qsin u_sin_e (.clk(clk), .en(en), .arg(a_se1), .sin_q16(se5));
  rtt_qsin u_cos_e (.clk(clk), .en(en), .arg(a_ce1), .sin_q16(ce5));

  // --------------------------------------------------------------------------
  // stage 2: squares, heading error in radians, beta*v_d
  // --------------------------------------------------------------------------
  logic [31:0]          wmag, vmag;
  logic [63:0]          w2_2, v2_2;
  logic signed [RW-1:0] erad2;
  logic signed [BVW-1:0] bv2;
  logic signed [63:0]   p_erad, p_bv;

  always_comb begin
    wmag   = wd1[31] ? 32'(-wd1) : 32'(wd1);
    vmag   = vd1[31] ? 32'(-vd1) : 32'(vd1);
    p_erad = eb1 * PI_Q16;
    p_bv   = $signed({1'b0, beta}) * vd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w2_2  <= wmag * wmag;
      v2_2  <= vmag * vmag;
      erad2 <= RW'(shr_trunc(p_erad, 6'd15));
      bv2   <= BVW'(shr_trunc(p_bv, 6'd16));
    end
  end

  // --------------------------------------------------------------------------
  // stages 3..5: R = (w_d^2 >> 8) + floor(beta*v_d^2 / 2^24)
  // --------------------------------------------------------------------------
  logic [55:0] ma3, w2s3;
  logic [31:0] mb3;
  logic [47:0] mc3;
  logic [63:0] s1_4, s2_4, rad5;

  always_ff @(posedge clk) begin
    if (en) begin
      ma3  <= beta * v2_2[55:24];
      mb3  <= beta * v2_2[63:56];
      mc3  <= beta * v2_2[23:0];
      w2s3 <= w2_2[63:8];
      s1_4 <= (64'(mb3) << 32) + 64'(ma3);
      s2_4 <= 64'(w2s3) + 64'(mc3[47:24]);
      rad5 <= s1_4 + s2_4;
    end
  end

  // stages 6..37: floor square root, one result bit per stage
  logic [63:0] sq_x [32];
  logic [63:0] sq_r [32];

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] xi, ri, trial;
    if (j == 0) begin : g_head
      assign xi = rad5;
      assign ri = '0;
    end else begin : g_tail
      assign xi = sq_x[j-1];
      assign ri = sq_r[j-1];
    end
    assign trial = ri + SQ_BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (xi >= trial) begin
          sq_x[j] <= xi - trial;
          sq_r[j] <= (ri >> 1) + SQ_BIT;
        end else begin
          sq_x[j] <= xi;
          sq_r[j] <= ri >> 1;
        end
      end
    end
  end

  // stage 38: k = zeta*sqrt(R) >> 11
  logic [55:0]   kprod;
  logic [KW-1:0] k38;

  assign kprod = zeta * sq_r[31][31:0];

  always_ff @(posedge clk) begin
    if (en) k38 <= kprod[55:11];
  end

  // --------------------------------------------------------------------------
  // delay lines to realign the error path
  // --------------------------------------------------------------------------
  logic signed [32:0]    dx_d [4];
  logic signed [32:0]    dy_d [4];
  logic signed [31:0]    vd_d [4];
  logic signed [31:0]    wd_d [42];
  logic signed [RW-1:0]  erad_d [36];
  logic signed [BVW-1:0] bv_d [22];

  always_ff @(posedge clk) begin
    if (en) begin
      dx_d[0]   <= dx1;
      dy_d[0]   <= dy1;
      vd_d[0]   <= vd1;
      wd_d[0]   <= wd1;
      erad_d[0] <= erad2;
      bv_d[0]   <= bv2;
      for (int i = 1; i < 4; i++) begin
        dx_d[i] <= dx_d[i-1];
        dy_d[i] <= dy_d[i-1];
        vd_d[i] <= vd_d[i-1];
      end
      for (int i = 1; i < 42; i++) wd_d[i] <= wd_d[i-1];
      for (int i = 1; i < 36; i++) erad_d[i] <= erad_d[i-1];
      for (int i = 1; i < 22; i++) bv_d[i] <= bv_d[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: rotation products, v_d*cos(e), divider setup
  // --------------------------------------------------------------------------
  logic signed [63:0] p_cx, p_sy, p_cy, p_sx, p_vc;
  logic signed [34:0] pcx6, psy6, pcy6, psx6;
  logic signed [33:0] vt6;
  logic [33:0]        num6;
  logic [17:0]        den6;
  logic               cap6, zero6;
  logic [16:0]        semag;
  logic [17:0]        emag;
  logic [34:0]        capref;

  always_comb begin
    p_cx   = cr5 * dx_d[3];
    p_sy   = sr5 * dy_d[3];
    p_cy   = cr5 * dy_d[3];
    p_sx   = sr5 * dx_d[3];
    p_vc   = vd_d[3] * ce5;
    semag  = se5[17] ? 17'(-se5) : 17'(se5);
    emag   = erad_d[2][RW-1] ? 18'(-erad_d[2]) : 18'(erad_d[2]);
    capref = (35'(emag) << 16) + 35'(emag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcx6  <= 35'(shr_trunc(p_cx, 6'd16));
      psy6  <= 35'(shr_trunc(p_sy, 6'd16));
      pcy6  <= 35'(shr_trunc(p_cy, 6'd16));
      psx6  <= 35'(shr_trunc(p_sx, 6'd16));
      vt6   <= 34'(shr_trunc(p_vc, 6'd16));
      num6  <= {1'b0, semag, 16'd0};
      den6  <= emag;
      cap6  <= {1'b0, semag, 16'd0} >= capref;
      zero6 <= (erad_d[2] == '0);
    end
  end

  // stage 7: robot-frame errors
  logic signed [EW-1:0] ex7, ey7;

  always_ff @(posedge clk) begin
    if (en) begin
      ex7 <= EW'(pcx6) + EW'(psy6);
      ey7 <= EW'(pcy6) - EW'(psx6);
    end
  end

  // stages 7..23: restoring divide for sinc, one quotient bit per stage
  logic [34:0] dv_rem [17];
  logic [16:0] dv_q   [17];
  logic [17:0] dv_den [17];
  logic        dv_cap [17];
  logic        dv_zero[17];

  for (genvar i = 0; i < 17; i++) begin : g_div
    localparam int B = 16 - i;
    logic [34:0] ri, sh;
    logic [16:0] qi;
    logic [17:0] di;
    logic        ci, zi;
    if (i == 0) begin : g_head
      assign ri = 35'(num6);
      assign qi = '0;
      assign di = den6;
      assign ci = cap6;
      assign zi = zero6;
    end else begin : g_tail
      assign ri = dv_rem[i-1];
      assign qi = dv_q[i-1];
      assign di = dv_den[i-1];
      assign ci = dv_cap[i-1];
      assign zi = dv_zero[i-1];
    end
    assign sh = 35'(di) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[i]  <= di;
        dv_cap[i]  <= ci;
        dv_zero[i] <= zi;
        if (ri >= sh) begin
          dv_rem[i] <= ri - sh;
          dv_q[i]   <= qi | (17'd1 << B);
        end else begin
          dv_rem[i] <= ri;
          dv_q[i]   <= qi;
        end
      end
    end
  end

  // stage 24: sinc, exactly one for zero error, capped at one
  logic [16:0] sinc24;

  always_ff @(posedge clk) begin
    if (en) sinc24 <= (dv_zero[16] || dv_cap[16]) ? 17'd65536 : dv_q[16];
  end

  // stage 25: beta*v_d*sinc
  logic signed [63:0]    p_bvs;
  logic signed [BVW-1:0] bvs25;

  assign p_bvs = bv_d[21] * $signed({1'b0, sinc24});

  always_ff @(posedge clk) begin
    if (en) bvs25 <= BVW'(shr_trunc(p_bvs, 6'd16));
  end

  logic signed [EW-1:0]  ex_d [31];
  logic signed [EW-1:0]  ey_d [31];
  logic signed [BVW-1:0] bvs_d [13];
  logic signed [33:0]    vt_d [36];

  always_ff @(posedge clk) begin
    if (en) begin
      ex_d[0]  <= ex7;
      ey_d[0]  <= ey7;
      bvs_d[0] <= bvs25;
      vt_d[0]  <= vt6;
      for (int i = 1; i < 31; i++) begin
        ex_d[i] <= ex_d[i-1];
        ey_d[i] <= ey_d[i-1];
      end
      for (int i = 1; i < 13; i++) bvs_d[i] <= bvs_d[i-1];
      for (int i = 1; i < 36; i++) vt_d[i] <= vt_d[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // stages 39..42: wide products k*e_x, k*e, beta*v_d*sinc*e_y
  // --------------------------------------------------------------------------
  logic signed [rtt_pkg::PROD_W-1:0] kv42, kw42, t3_42;

  rtt_mul #(.WA(KW + 1), .WB(EW), .SHIFT(16)) u_mul_kex (
    .clk(clk), .en(en), .a($signed({1'b0, k38})), .b(ex_d[30]), .p(kv42)
  );

  rtt_mul #(.WA(KW + 1), .WB(33), .SHIFT(16)) u_mul_ke (
    .clk(clk), .en(en), .a($signed({1'b0, k38})), .b(33'(erad_d[35])), .p(kw42)
  );

  rtt_mul #(.WA(BVW), .WB(EW), .SHIFT(16)) u_mul_bey (
    .clk(clk), .en(en), .a(bvs_d[12]), .b(ey_d[30]), .p(t3_42)
  );

  // --------------------------------------------------------------------------
  // stages 43..44: sums, saturation, output register
  // --------------------------------------------------------------------------
  localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
  localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

  logic signed [63:0] vsum43, wpart43;
  logic signed [64:0] v65, w65;
  logic signed [31:0] vout, wout;
  logic               vsat, wsat;

  always_ff @(posedge clk) begin
    if (en) begin
      vsum43  <= 64'(kv42) + 64'(vt_d[35]);
      wpart43 <= 64'(kw42) + 64'(t3_42);
    end
  end

  always_comb begin
    v65  = 65'(vsum43);
    w65  = 65'(wd_d[41]) + 65'(wpart43);
    vsat = (v65 > SAT_MAX) || (v65 < SAT_MIN);
    wsat = (w65 > SAT_MAX) || (w65 < SAT_MIN);
    if (v65 > SAT_MAX)      vout = 32'(SAT_MAX);
    else if (v65 < SAT_MIN) vout = 32'(SAT_MIN);
    else                    vout = 32'(v65);
    if (w65 > SAT_MAX)      wout = 32'(SAT_MAX);
    else if (w65 < SAT_MIN) wout = 32'(SAT_MIN);
    else                    wout = 32'(w65);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_out.command_speed     <= vout;
      cmd_out.command_turn_rate <= wout;
      cmd_out.saturated         <= vsat || wsat;
    end
  end

endmodule

// ===== sv/rtt_checker.sv =====
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks of the RAMSETE tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "ramsete_trajectory_tracker_top_assert.svh"

module rtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] command_speed,
  input logic [31:0] command_turn_rate,
  input logic        saturated
);

  `RTT_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "item dropped under stall")
  `RTT_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(command_speed) && $stable(command_turn_rate) && $stable(saturated), "payload moved under stall")
  `RTT_ASSERT(a_sat_rail, clk, rst, out_valid && saturated |-> command_speed == 32'h7fffffff || command_speed == 32'h80000000 || command_turn_rate == 32'h7fffffff || command_turn_rate == 32'h80000000, "flag without a clipped command")
  `RTT_ASSERT(a_ready_flow, clk, rst, out_ready |-> in_ready, "input stalled while output drains")
  `RTT_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output valid right after reset")

endmodule

bind ramsete_trajectory_tracker_top rtt_checker u_rtt_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (pose_in.ready),
  .out_valid         (cmd_out.valid),
  .out_ready         (cmd_out.ready),
  .command_speed     (cmd_out.command_speed),
  .command_turn_rate (cmd_out.command_turn_rate),
  .saturated         (cmd_out.saturated)
);

// ===== dv/rtt_tracking_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_tracking_checker
// Watches the pose, command and config ports of the tracker, computes the
// expected velocity command for every accepted pose item and compares it
// with the commands that come out, in order.
// ----------------------------------------------------------------------------
module rtt_tracking_checker (
  input  logic                          clk,
  input  logic                          rst,
  rtt_pose_if                           pose,
  rtt_cmd_if                            cmd,
  input  logic                          cfg_we,
  input  logic [rtt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtt_pkg::CW-1:0]        cfg_data,
  output int                            fail_count,
  output int                            cmds_pending
);
  import rtt_pkg::*;

  typedef struct packed {
    logic signed [XW-1:0] speed;
    logic signed [XW-1:0] turn_rate;
    logic                 clipped;
  } command_t;

  localparam longint HALF_TURN_Q16 = 205887;  // pi in Q16.16

  logic [CW-1:0] zeta;
  logic [CW-1:0] beta;
  command_t      expected_cmds[$];

  assign cmds_pending = expected_cmds.size();

  function automatic bit [63:0] magnitude(longint a);
    return (a < 0) ? bit'(0) - a : a;
  endfunction

  function automatic longint quarter_wave(bit [63:0] r);
    bit [63:0] z2;
    bit [63:0] t;
    z2 = (r * r) >> 14;
    t  = (64'(TRIG_C5) * z2) >> 14;
    t  = 64'(TRIG_C3) - t;
    t  = (t * z2) >> 14;
    t  = 64'(TRIG_C1) - t;
    t  = (t * r) >> 14;
    return longint'(t);
  endfunction

  function automatic longint angle_sin(bit [15:0] a);
    bit [63:0] r;
    r = a[13:0];
    case (a[15:14])
      2'd0: return quarter_wave(r);
      2'd1: return quarter_wave(64'd16384 - r);
      2'd2: return -quarter_wave(r);
      default: return -quarter_wave(64'd16384 - r);
    endcase
  endfunction

  // exact product, shifted right with truncation toward zero, clamped to +-2^61
  function automatic longint scale_mul(longint a, longint b, int s);
    bit         neg;
    bit [127:0] prod;
    bit [63:0]  mag;
    neg  = (a < 0) != (b < 0);
    prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    prod = prod >> s;
    if (prod > {64'd0, PROD_LIM}) prod = {64'd0, PROD_LIM};
    mag = prod[63:0];
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic bit [63:0] floor_root(bit [63:0] x);
    bit [63:0] root;
    bit [63:0] trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic command_t track_command(
      logic signed [XW-1:0] rx, logic signed [XW-1:0] ry, logic [AW-1:0] rh,
      logic signed [XW-1:0] tx, logic signed [XW-1:0] ty, logic [AW-1:0] th,
      logic signed [XW-1:0] vd_in, logic signed [XW-1:0] wd_in);
    longint    dx, dy, cr, sr, ex, ey, eb, erad, ce, se, sinc, vd, wd, v, w;
    bit [15:0] ediff;
    bit [63:0] w2, v2, rad, gain, q;
    command_t  c;
    vd = vd_in;
    wd = wd_in;
    dx = longint'(tx) - longint'(rx);
    dy = longint'(ty) - longint'(ry);
    cr = angle_sin(rh + 16'd16384);
    sr = angle_sin(rh);
    ex = scale_mul(cr, dx, 16) + scale_mul(sr, dy, 16);
    ey = scale_mul(cr, dy, 16) - scale_mul(sr, dx, 16);
    ediff = th - rh;
    eb    = longint'($signed(ediff));
    erad  = scale_mul(eb, HALF_TURN_Q16, 15);
    ce    = angle_sin(ediff + 16'd16384);
    se    = angle_sin(ediff);
    sinc  = 65536;
    if (eb != 0 && erad != 0) begin
      q    = (magnitude(se) << 16) / magnitude(erad);
      sinc = (q > 65536) ? 65536 : longint'(q);
    end
    w2   = magnitude(wd) * magnitude(wd);
    v2   = magnitude(vd) * magnitude(vd);
    rad  = (w2 >> 8) + 64'(beta) * (v2 >> 24) + ((64'(beta) * (v2 & 64'hFF_FFFF)) >> 24);
    gain = (64'(zeta) * floor_root(rad)) >> 11;
    v = scale_mul(vd, ce, 16) + scale_mul(longint'(gain), ex, 16);
    w = wd + scale_mul(longint'(gain), erad, 16)
      + scale_mul(scale_mul(scale_mul(longint'(beta), vd, 16), sinc, 16), ey, 16);
    c.clipped = 1'b0;
    if (v > 64'sd2147483647) begin v = 64'sd2147483647; c.clipped = 1'b1; end
    if (v < -64'sd2147483648) begin v = -64'sd2147483648; c.clipped = 1'b1; end
    if (w > 64'sd2147483647) begin w = 64'sd2147483647; c.clipped = 1'b1; end
    if (w < -64'sd2147483648) begin w = -64'sd2147483648; c.clipped = 1'b1; end
    c.speed     = v[31:0];
    c.turn_rate = w[31:0];
    return c;
  endfunction

  always @(posedge clk) begin
    command_t exp_c;
    if (rst) begin
      zeta <= ZETA_RST;
      beta <= BETA_RST;
      expected_cmds.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ZETA) zeta <= cfg_data;
        else if (cfg_index == CFG_BETA) beta <= cfg_data;
      end
      if (pose.valid && pose.ready)
        expected_cmds.push_back(track_command(pose.robot_x, pose.robot_y,
          pose.robot_heading, pose.target_x, pose.target_y, pose.target_heading,
          pose.target_speed, pose.target_turn_rate));
      if (cmd.valid && cmd.ready) begin
        if (expected_cmds.size() == 0) begin
          if (fail_count < 10) $display("unexpected command item v=%0d w=%0d",
                                        cmd.command_speed, cmd.command_turn_rate);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = expected_cmds.pop_front();
          if (exp_c.speed !== cmd.command_speed || exp_c.turn_rate !== cmd.command_turn_rate
              || exp_c.clipped !== cmd.saturated) begin
            if (fail_count < 10)
              $display("command mismatch: exp v=%0d w=%0d sat=%0d, got v=%0d w=%0d sat=%0d",
                       exp_c.speed, exp_c.turn_rate, exp_c.clipped, cmd.command_speed,
                       cmd.command_turn_rate, cmd.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/ramsete_trajectory_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramsete_trajectory_tracker_top_tb
// Drives pose items through the RAMSETE tracker under random back-pressure
// and several zeta/beta settings; the checker predicts each command.
// ----------------------------------------------------------------------------
module ramsete_trajectory_tracker_top_tb;
  import rtt_pkg::*;

  localparam int ITEMS_PER_PHASE = 140;
  localparam int DRAIN_CYCLES    = 60;   // idle slack after the last command is out

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ZETA;
  logic [CW-1:0] cfg_data = '0;
  int            fail_count;
  int            cmds_pending;
  bit            calm;          // no sender gaps while set
  int            cmds_taken;

  rtt_pose_if pose_in();
  rtt_cmd_if  cmd_out();

  ramsete_trajectory_tracker_top dut (
    .clk(clk), .rst(rst), .pose_in(pose_in), .cmd_out(cmd_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rtt_tracking_checker u_check (
    .clk(clk), .rst(rst), .pose(pose_in), .cmd(cmd_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .cmds_pending(cmds_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    logic signed [XW-1:0] rx, ry, tx, ty, vd, wd;
    logic [AW-1:0]        rh, th;
  } pose_item_t;

  initial begin
    pose_in.valid = 1'b0;
    pose_in.robot_x = '0; pose_in.robot_y = '0; pose_in.robot_heading = '0;
    pose_in.target_x = '0; pose_in.target_y = '0; pose_in.target_heading = '0;
    pose_in.target_speed = '0; pose_in.target_turn_rate = '0;
    cmd_out.ready = 1'b0;
  end

  // sign-extended value in [-span, span]
  function automatic logic [31:0] near_zero(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic pose_item_t make_pose(logic [31:0] rx, ry, logic [15:0] rh,
      logic [31:0] tx, ty, logic [15:0] th, logic [31:0] vd, wd);
    pose_item_t p;
    p.rx = rx; p.ry = ry; p.rh = rh; p.tx = tx; p.ty = ty; p.th = th;
    p.vd = vd; p.wd = wd;
    return p;
  endfunction

  // mostly plausible tracking scenes, some full-range noise and corner values
  function automatic pose_item_t random_pose();
    pose_item_t p;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      p.rx = near_zero(1310720);                 // +-20 m
      p.ry = near_zero(1310720);
      p.tx = p.rx + near_zero(65536);            // goal within 1 m on each axis
      p.ty = p.ry + near_zero(65536);
      p.rh = $urandom;
      p.th = p.rh + near_zero(4096);
      p.vd = near_zero(262144);                  // +-4 m/s
      p.wd = near_zero(262144);
    end else if (kind == 7) begin
      p.rx = $urandom; p.ry = $urandom; p.tx = $urandom; p.ty = $urandom;
      p.rh = $urandom; p.th = $urandom; p.vd = $urandom; p.wd = $urandom;
    end else if (kind == 8) begin
      p.rx = $urandom; p.ry = $urandom; p.tx = $urandom; p.ty = $urandom;
      p.rh = $urandom; p.th = p.rh;              // zero heading error
      p.vd = near_zero(655360); p.wd = near_zero(655360);
    end else begin
      p.rx = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      p.ry = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      p.tx = ~p.rx; p.ty = $urandom;
      p.rh = $urandom; p.th = p.rh + 16'h8000 + near_zero(2);
      p.vd = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      p.wd = $urandom;
    end
    return p;
  endfunction

  task automatic send_pose(pose_item_t p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      pose_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pose_in.robot_x <= p.rx;   pose_in.robot_y <= p.ry;   pose_in.robot_heading <= p.rh;
    pose_in.target_x <= p.tx;  pose_in.target_y <= p.ty;  pose_in.target_heading <= p.th;
    pose_in.target_speed <= p.vd; pose_in.target_turn_rate <= p.wd;
    pose_in.valid <= 1'b1;
    do @(posedge clk); while (!pose_in.ready);
  endtask

  // drop valid and wait until every command is out, plus pipeline slack
  task automatic drain_all();
    pose_in.valid <= 1'b0;
    do @(posedge clk); while (cmds_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gains(logic [CW-1:0] z, logic [CW-1:0] b);
    cfg_we <= 1'b1; cfg_index <= CFG_ZETA; cfg_data <= z;
    @(posedge clk);
    cfg_index <= CFG_BETA; cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls per item, plus one long hold-off so the
  // pipeline backs up and the input side has to stall.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    cmds_taken = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!held && cmds_taken == 60) begin
        held = 1'b1;
        cmd_out.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        stall = calm ? 0 : $urandom_range(0, 8);
        if (stall > 0) begin
          cmd_out.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      cmd_out.ready <= 1'b1;
      do @(posedge clk); while (!cmd_out.valid);
      cmds_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    logic [CW-1:0] zetas[5];
    logic [CW-1:0] betas[5];
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    zetas = '{ZETA_RST, 24'd0, 24'hFF_FFFF, 24'd45875, 24'd1};
    betas = '{BETA_RST, 24'd0, 24'hFF_FFFF, 24'd65536, 24'hFF_FFFF};

    // directed corners at reset gains
    send_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0));
    send_pose(make_pose(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0));
    send_pose(make_pose(32'h8000_0000, 32'h8000_0000, 16'h0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_pose(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000,
                        32'h8000_0000, 32'h8000_0000, 16'h7FFF, 32'h8000_0000, 32'h8000_0000));
    // heading wrap: error of exactly pi, just past it, and one step across the sign boundary
    send_pose(make_pose(0, 0, 16'h0000, 0, 32'h0001_0000, 16'h8000, 32'h0002_0000, 0));
    send_pose(make_pose(0, 0, 16'hFFFF, 0, 32'h0001_0000, 16'h7FFF, 32'h0002_0000, 0));
    send_pose(make_pose(0, 0, 16'h7FFF, 0, 32'h0001_0000, 16'h8000, 32'h0002_0000, 0));
    send_pose(make_pose(0, 0, 16'h8000, 0, 32'h0001_0000, 16'h0001, 32'hFFFE_0000, 0));
    // each quadrant of robot heading, zero heading error
    for (int q = 0; q < 4; q++)
      send_pose(make_pose(32'h0001_0000, 32'hFFFF_0000, 16'(q * 16384 + 100),
                          32'h0003_0000, 32'h0002_0000, 16'(q * 16384 + 100),
                          32'h0001_8000, 32'hFFFF_8000));
    // quarter-wave ends
    send_pose(make_pose(0, 0, 16'h4000, 32'h0001_0000, 0, 16'hC000, 32'h0001_0000, 32'h0001_0000));
    send_pose(make_pose(0, 0, 16'hC000, 0, 32'h0001_0000, 16'h4000, 32'hFFFF_0000, 0));
    // saturation in both directions
    send_pose(make_pose(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0));
    send_pose(make_pose(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 0));
    send_pose(make_pose(0, 0, 0, 0, 0, 16'h2000, 0, 32'h7FFF_FFFF));
    send_pose(make_pose(0, 0, 0, 0, 0, 16'hE000, 0, 32'h8000_0000));
    send_pose(make_pose(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 16'h0001, 32'h7FFF_FFFF, 0));
    // tiny heading errors next to zero
    send_pose(make_pose(0, 0, 16'h0000, 32'h0000_8000, 32'h0000_8000, 16'h0001, 32'h0001_0000, 0));
    send_pose(make_pose(0, 0, 16'h0001, 32'h0000_8000, 32'h0000_8000, 16'h0000, 32'h0001_0000, 0));

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        // sender pause: wait for every command before touching the gains
        drain_all();
        write_gains(zetas[ph], betas[ph]);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        calm = (i >= 60 && i < 90);   // a stretch of back-to-back items
        send_pose(random_pose());
      end
      calm = 1'b0;
    end
    drain_all();

    if (fail_count == 0)
      $display("ramsete_trajectory_tracker_top verification clean");
    else
      $display("ramsete_trajectory_tracker_top verification failed");
    $finish;
  end

  initial begin
    #1000000;
    $display("ramsete_trajectory_tracker_top verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/rtt_pkg.sv
sv/rtt_pose_if.sv
sv/rtt_cmd_if.sv
sv/rtt_qsin.sv
sv/rtt_mul.sv
sv/ramsete_trajectory_tracker_top.sv
sv/rtt_checker.sv
dv/rtt_tracking_checker.sv
dv/ramsete_trajectory_tracker_top_tb.sv
